// File: hw/rtl/ecd_pkg.sv
// Shared types, constants and helpers for the low-S DER signature encoder.
// Used by ecd_alu, ecd_packer and the top level ecdsa_low_s_der_encoder.
package ecd_pkg;

  localparam int WORD_W   = 64;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_APPEND_SIGHASH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGHASH_TYPE   = 8'd1;

  localparam logic [7:0] DER_TAG_SEQ = 8'h30;
  localparam logic [7:0] DER_TAG_INT = 8'h02;
  localparam logic [7:0] DER_PAD     = 8'h00;

  // secp256k1 group order n and floor(n/2), most significant word first
  localparam logic [WORD_W-1:0] ORDER_N [0:3] = '{
    64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFE,
    64'hBAAEDCE6AF48A03B, 64'hBFD25E8CD0364141
  };
  localparam logic [WORD_W-1:0] HALF_ORDER [0:3] = '{
    64'h7FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
    64'h5D576E7357A4501D, 64'hDFE92F46681B20A0
  };

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CMP,
    ST_SUB,
    ST_SCAN,
    ST_HDR_SEQ,
    ST_HDR_LEN,
    ST_INT_TAG,
    ST_INT_LEN,
    ST_INT_PAD,
    ST_INT_BODY,
    ST_SIGHASH
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] diff;
    logic              borrow;
    logic              eq;
    logic              gt;
  } alu_res_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } push_t;

  typedef struct packed {
    logic [2:0] lz;   // leading zero bytes of a nonzero word
    logic       msb;  // top bit of the first nonzero byte
  } lead_t;

  function automatic lead_t lead_bytes(input logic [WORD_W-1:0] w);
    lead_t res;
    logic  hit;
    res = '0;
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!hit && (w[WORD_W-1-8*k -: 8] != 8'h00)) begin
        hit     = 1'b1;
        res.lz  = 3'(k);
        res.msb = w[WORD_W-1-8*k];
      end
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/ecd_alu.sv
// Shared 64-bit subtract-with-borrow and magnitude compare unit.
// Depends on ecd_pkg for the result struct.
module ecd_alu (
  input  logic [ecd_pkg::WORD_W-1:0] a,
  input  logic [ecd_pkg::WORD_W-1:0] b,
  input  logic                       borrow_in,
  output ecd_pkg::alu_res_t          res
);
  import ecd_pkg::*;

  logic [WORD_W:0] full;

  assign full       = {1'b0, a} - {1'b0, b} - {{WORD_W{1'b0}}, borrow_in};
  assign res.diff   = full[WORD_W-1:0];
  assign res.borrow = full[WORD_W];
  assign res.eq     = (a == b);
  // valid as a compare only with borrow_in low
  assign res.gt     = !full[WORD_W] && (a != b);

endmodule

// File: hw/rtl/ecd_packer.sv
// Packs the DER byte stream into 64-bit result words, top lane first,
// behind an output register. Depends on ecd_pkg for the push struct.
module ecd_packer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ecd_pkg::push_t             push,
  output logic                       push_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ecd_pkg::WORD_W-1:0] out_der_word,
  output logic [3:0]                 out_byte_count,
  output logic                       out_last_word
);
  import ecd_pkg::*;

  logic [WORD_W-1:0] acc_r;
  logic [2:0]        cnt_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [3:0]        out_count_r;
  logic              out_last_r;
  logic [WORD_W-1:0] lane_word;
  logic              fire;

  assign push_ready = !out_valid_r || out_ready;
  assign fire       = push.valid && push_ready;
  assign lane_word  = acc_r | ({push.data, {(WORD_W-8){1'b0}}} >> {cnt_r, 3'b000});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      if (cnt_r == 3'd7 || push.last) begin
        out_valid_r <= 1'b1;
        out_word_r  <= lane_word;
        out_count_r <= {1'b0, cnt_r} + 4'd1;
        out_last_r  <= push.last;
        acc_r       <= '0;
        cnt_r       <= '0;
      end else begin
        if (out_ready) out_valid_r <= 1'b0;
        acc_r <= lane_word;
        cnt_r <= cnt_r + 3'd1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_der_word   = out_word_r;
  assign out_byte_count = out_count_r;
  assign out_last_word  = out_last_r;

endmodule

// File: hw/rtl/ecdsa_low_s_der_encoder.sv
// Top level of the low-S DER encoder: sequencer, signature store, config.
// Depends on ecd_pkg, ecd_alu and ecd_packer.
//
// A signature is taken as eight 64-bit words, one per cycle (r then s, most
// significant word first); the input is not ready while a signature is being
// encoded. After the eighth transfer one 64-bit compare/subtract unit checks
// s against n/2 word by word and, if s is high, forms n - s; then the eight
// words are scanned for leading zero bytes. The DER stream (plus the optional
// sighash byte, at most 73 bytes in all) then leaves one byte per cycle
// through the packer while the result side does not stall; the packer hands
// out words, the last one possibly partial, through an output register.
// Config writes are always accepted and should be made while the block is
// idle.
module ecdsa_low_s_der_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ecd_pkg::WORD_W-1:0]    in_sig_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ecd_pkg::WORD_W-1:0]    out_der_word,
  output logic [3:0]                    out_byte_count,
  output logic                          out_last_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ecd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import ecd_pkg::*;

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] store_r [0:7];
  logic [2:0]        load_cnt_r;
  logic [5:0]        idx_r;
  logic              borrow_r;
  logic              sel_r;
  logic [5:0]        first_r [0:1];
  logic              found_r [0:1];
  logic              msb_r   [0:1];
  logic              append_r;
  logic [7:0]        sighash_r;

  logic [WORD_W-1:0] alu_a, alu_b;
  logic              alu_bin;
  alu_res_t          alu;
  push_t             push;
  logic              push_ready;

  logic [WORD_W-1:0] scan_word;
  lead_t             lead;
  logic              pad_eff [0:1];
  logic [5:0]        int_len [0:1];
  logic [7:0]        seq_len;
  logic [WORD_W-1:0] body_word;
  logic [7:0]        body_byte;
  logic              int_end;
  logic              in_fire;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  ecd_alu u_alu (
    .a         (alu_a),
    .b         (alu_b),
    .borrow_in (alu_bin),
    .res       (alu)
  );

  ecd_packer u_packer (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_ready     (push_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_der_word   (out_der_word),
    .out_byte_count (out_byte_count),
    .out_last_word  (out_last_word)
  );

  // an all-zero scalar shows up as first == 32 with a forced pad byte
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      pad_eff[k] = !found_r[k] || msb_r[k];
      int_len[k] = 6'd32 - first_r[k] + {5'b0, pad_eff[k]};
    end
    seq_len = 8'd4 + {2'b0, int_len[0]} + {2'b0, int_len[1]};
  end

  assign scan_word = store_r[idx_r[2:0]];
  assign lead      = lead_bytes(scan_word);
  assign body_word = store_r[{sel_r, idx_r[4:3]}];
  assign body_byte = 8'(body_word >> {~idx_r[2:0], 3'b000});

  // last byte of the current INTEGER
  always_comb begin
    int_end = 1'b0;
    if (state_r == ST_INT_PAD)  int_end = (first_r[sel_r] == 6'd32);
    if (state_r == ST_INT_BODY) int_end = (idx_r == 6'd31);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (in_fire && load_cnt_r == 3'd7) state_nxt = ST_CMP;
      ST_CMP: begin
        if (!alu.eq) state_nxt = alu.gt ? ST_SUB : ST_SCAN;
        else if (idx_r[1:0] == 2'd3) state_nxt = ST_SCAN;
      end
      ST_SUB:      if (idx_r[1:0] == 2'd0) state_nxt = ST_SCAN;
      ST_SCAN:     if (idx_r[2:0] == 3'd7) state_nxt = ST_HDR_SEQ;
      ST_HDR_SEQ:  if (push_ready) state_nxt = ST_HDR_LEN;
      ST_HDR_LEN:  if (push_ready) state_nxt = ST_INT_TAG;
      ST_INT_TAG:  if (push_ready) state_nxt = ST_INT_LEN;
      ST_INT_LEN:  if (push_ready) state_nxt = pad_eff[sel_r] ? ST_INT_PAD : ST_INT_BODY;
      ST_INT_PAD, ST_INT_BODY: begin
        if (push_ready) begin
          if (int_end) begin
            if (!sel_r)        state_nxt = ST_INT_TAG;
            else if (append_r) state_nxt = ST_SIGHASH;
            else               state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_INT_BODY;
          end
        end
      end
      ST_SIGHASH:  if (push_ready) state_nxt = ST_LOAD;
      default:     state_nxt = ST_LOAD;
    endcase
  end

  // outputs: shared unit operands and byte pushes
  always_comb begin
    alu_a      = store_r[{1'b1, idx_r[1:0]}];
    alu_b      = HALF_ORDER[idx_r[1:0]];
    alu_bin    = 1'b0;
    push.valid = 1'b0;
    push.data  = DER_PAD;
    push.last  = 1'b0;
    case (state_r)
      ST_SUB: begin
        alu_a   = ORDER_N[idx_r[1:0]];
        alu_b   = store_r[{1'b1, idx_r[1:0]}];
        alu_bin = borrow_r;
      end
      ST_HDR_SEQ: begin
        push.valid = 1'b1;
        push.data  = DER_TAG_SEQ;
      end
      ST_HDR_LEN: begin
        push.valid = 1'b1;
        push.data  = seq_len;
      end
      ST_INT_TAG: begin
        push.valid = 1'b1;
        push.data  = DER_TAG_INT;
      end
      ST_INT_LEN: begin
        push.valid = 1'b1;
        push.data  = {2'b0, int_len[sel_r]};
      end
      ST_INT_PAD: begin
        push.valid = 1'b1;
        push.data  = DER_PAD;
        push.last  = int_end && sel_r && !append_r;
      end
      ST_INT_BODY: begin
        push.valid = 1'b1;
        push.data  = body_byte;
        push.last  = int_end && sel_r && !append_r;
      end
      ST_SIGHASH: begin
        push.valid = 1'b1;
        push.data  = sighash_r;
        push.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      append_r   <= 1'b1;
      sighash_r  <= 8'h01;
    end else begin
      state_r <= state_nxt;
      if (in_fire) load_cnt_r <= load_cnt_r + 3'd1;
      if (cfg_valid && cfg_index == CFG_APPEND_SIGHASH) append_r  <= cfg_data[0];
      if (cfg_valid && cfg_index == CFG_SIGHASH_TYPE)   sighash_r <= cfg_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        if (in_fire) store_r[load_cnt_r] <= in_sig_word;
        idx_r <= '0;
      end
      ST_CMP: begin
        borrow_r <= 1'b0;
        if (state_nxt == ST_SUB)       idx_r <= 6'd3;
        else if (state_nxt == ST_SCAN) idx_r <= '0;
        else                           idx_r <= idx_r + 6'd1;
        if (state_nxt == ST_SCAN) begin
          first_r <= '{6'd0, 6'd0};
          found_r <= '{1'b0, 1'b0};
        end
      end
      ST_SUB: begin
        store_r[{1'b1, idx_r[1:0]}] <= alu.diff;
        borrow_r <= alu.borrow;
        idx_r    <= idx_r - 6'd1;
        if (state_nxt == ST_SCAN) begin
          idx_r   <= '0;
          first_r <= '{6'd0, 6'd0};
          found_r <= '{1'b0, 1'b0};
        end
      end
      ST_SCAN: begin
        if (!found_r[idx_r[2]]) begin
          if (scan_word != '0) begin
            first_r[idx_r[2]] <= {1'b0, idx_r[1:0], lead.lz};
            found_r[idx_r[2]] <= 1'b1;
            msb_r[idx_r[2]]   <= lead.msb;
          end else begin
            first_r[idx_r[2]] <= first_r[idx_r[2]] + 6'd8;
          end
        end
        idx_r <= idx_r + 6'd1;
        sel_r <= 1'b0;
      end
      ST_INT_LEN, ST_INT_PAD: begin
        if (push_ready) idx_r <= first_r[sel_r];
        if (push_ready && int_end) sel_r <= 1'b1;
      end
      ST_INT_BODY: begin
        if (push_ready) idx_r <= idx_r + 6'd1;
        if (push_ready && int_end) sel_r <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule
